// File: sv/set_assoc_cache_tag_lookup_core_assert.svh
// Assertion macros for the tag lookup checker.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_CORE_ASSERT_SVH

// Check a property on every clock edge out of reset.
`define SATL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tag lookup check failed");

// Check a property on every clock edge while reset is held.
`define SATL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) !rst_ni |-> (prop)) \
    else $error("tag lookup reset check failed");

`endif

// File: sv/satl_pkg.sv
// Shared types and constants of the cache tag lookup.
package satl_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int LINE_BYTES = 32;
  localparam int SETS       = 128;
  localparam int WAYS       = 4;

  localparam int OFF_BITS   = $clog2(LINE_BYTES);
  localparam int SET_BITS   = $clog2(SETS);
  localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int WAY_BITS   = $clog2(WAYS);
  localparam int CNT_BITS   = WAY_BITS + 1;
  localparam int WLOG_BITS  = 2;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [SET_BITS-1:0] set_t;
  typedef logic [WAY_BITS-1:0] way_t;

  typedef struct packed {
    set_t set;
    tag_t tag;
  } req_t;

  typedef struct packed {
    way_t                 fifo;
    logic [WAYS-1:0]      vld;
    tag_t [WAYS-1:0]      tags;
  } row_t;

  localparam int ROW_BITS = $bits(row_t);

  typedef enum logic {
    POL_LRU  = 1'b0,
    POL_FIFO = 1'b1
  } policy_e;

  typedef enum logic {
    BK_IDLE,
    BK_UPDATE
  } back_state_e;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_WAYS   = 1'b1;

  typedef struct packed {
    policy_e               policy;
    logic [WLOG_BITS-1:0]  ways_log2;
  } cfg_t;

endpackage

// File: sv/satl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/satl_front.sv
// Front end: address split into set and tag, and a short request queue.
module satl_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [satl_pkg::ADDR_BITS-1:0] address_i,
  output logic                         full_o,
  output logic                         req_valid_o,
  output satl_pkg::req_t               req_o,
  input  logic                         req_pop_i
);

  satl_pkg::req_t                 q_q [satl_pkg::QDEPTH];
  logic [satl_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [satl_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [satl_pkg::QPTR_BITS:0]   cnt_q, cnt_d;
  logic                           wr_en, rd_en;
  satl_pkg::req_t                 req_in;

  assign req_in.set = address_i[satl_pkg::OFF_BITS +: satl_pkg::SET_BITS];
  assign req_in.tag = address_i[satl_pkg::ADDR_BITS-1 : satl_pkg::OFF_BITS + satl_pkg::SET_BITS];

  assign full_o      = (cnt_q == (satl_pkg::QPTR_BITS+1)'(satl_pkg::QDEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = q_q[rd_ptr_q];

  assign wr_en = push_i && !full_o;
  assign rd_en = req_pop_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + satl_pkg::QPTR_BITS'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + satl_pkg::QPTR_BITS'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + (satl_pkg::QPTR_BITS+1)'(1);
      2'b01:   cnt_d = cnt_q - (satl_pkg::QPTR_BITS+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

// File: sv/satl_back.sv
// Back end: set row read, tag compare, replacement update and result register.
module satl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  satl_pkg::cfg_t  cfg_i,
  input  logic            req_valid_i,
  input  satl_pkg::req_t  req_i,
  output logic            req_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic            hit_o
);

  satl_pkg::back_state_e      state_q, state_d;
  satl_pkg::req_t             cur_q, cur_d;
  logic                       rowv_q, rowv_d;
  logic [satl_pkg::SETS-1:0]  row_vld_q, row_vld_d;
  logic                       out_vld_q, out_vld_d;
  logic                       hit_q, hit_d;

  logic                            re, we;
  logic [satl_pkg::ROW_BITS-1:0]   rdata;
  satl_pkg::row_t                  old_row, new_row;
  logic [satl_pkg::WLOG_BITS-1:0]  wl;
  logic [satl_pkg::CNT_BITS-1:0]   n_cnt;
  satl_pkg::way_t                  n_m1, hidx, pos, fptr;
  logic [satl_pkg::WAYS-1:0]       match;
  logic                            hit, lru;

  satl_ram #(
    .WIDTH (satl_pkg::ROW_BITS),
    .DEPTH (satl_pkg::SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cur_q.set),
    .wdata_i (new_row),
    .re_i    (re),
    .raddr_i (req_i.set),
    .rdata_o (rdata)
  );

  always_comb begin
    old_row = rowv_q ? satl_pkg::row_t'(rdata) : '0;
    wl = (cfg_i.ways_log2 > satl_pkg::WLOG_BITS'(satl_pkg::WAY_BITS)) ?
         satl_pkg::WLOG_BITS'(satl_pkg::WAY_BITS) : cfg_i.ways_log2;
    n_cnt = satl_pkg::CNT_BITS'(1) << wl;
    n_m1  = satl_pkg::WAY_BITS'(n_cnt - satl_pkg::CNT_BITS'(1));
    for (int i = 0; i < satl_pkg::WAYS; i++) begin
      match[i] = old_row.vld[i] && (old_row.tags[i] == cur_q.tag) &&
                 (satl_pkg::CNT_BITS'(i) < n_cnt);
    end
    hit  = |match;
    hidx = '0;
    for (int i = satl_pkg::WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hidx = satl_pkg::WAY_BITS'(i);
      end
    end
    pos  = hit ? hidx : n_m1;
    lru  = (cfg_i.policy == satl_pkg::POL_LRU) || (n_cnt == satl_pkg::CNT_BITS'(1));
    fptr = old_row.fifo & n_m1;

    new_row = old_row;
    if (lru) begin
      new_row.tags[0] = cur_q.tag;
      new_row.vld[0]  = 1'b1;
      for (int i = 1; i < satl_pkg::WAYS; i++) begin
        if (satl_pkg::WAY_BITS'(i) <= pos) begin
          new_row.tags[i] = old_row.tags[i-1];
          new_row.vld[i]  = old_row.vld[i-1];
        end
      end
    end else if (!hit) begin
      new_row.tags[fptr] = cur_q.tag;
      new_row.vld[fptr]  = 1'b1;
      new_row.fifo       = (fptr + satl_pkg::WAY_BITS'(1)) & n_m1;
    end
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    rowv_d    = rowv_q;
    row_vld_d = row_vld_q;
    out_vld_d = out_vld_q && !pop_i;
    hit_d     = hit_q;
    req_pop_o = 1'b0;
    re        = 1'b0;
    we        = 1'b0;
    case (state_q)
      satl_pkg::BK_IDLE: begin
        if (req_valid_i && (!out_vld_q || pop_i)) begin
          req_pop_o = 1'b1;
          re        = 1'b1;
          cur_d     = req_i;
          rowv_d    = row_vld_q[req_i.set];
          state_d   = satl_pkg::BK_UPDATE;
        end
      end
      satl_pkg::BK_UPDATE: begin
        we                   = 1'b1;
        row_vld_d[cur_q.set] = 1'b1;
        out_vld_d            = 1'b1;
        hit_d                = hit;
        state_d              = satl_pkg::BK_IDLE;
      end
      default: state_d = satl_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= satl_pkg::BK_IDLE;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_vld_q <= row_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rowv_q <= rowv_d;
    hit_q  <= hit_d;
  end

  assign empty_o = !out_vld_q;
  assign hit_o   = hit_q;

endmodule

// File: sv/set_assoc_cache_tag_lookup_core.sv
// Tag array of a set-associative cache with LRU or FIFO replacement: top level.
// Each pushed byte address is split into a set index and a tag and looked up
// in the ways of its set that ways_log2 enables, four at most; the popped
// result is 1 on a hit and 0 on a miss, after which the set is updated by the
// selected policy. Addresses wait in a two-entry queue in front of the lookup
// engine, and one finished result waits in an output register. The engine
// reads the set's row from the tag RAM, then compares and writes the row
// back, and takes no new address until that read-modify-write on the single
// tag RAM is done and the output register is free or being popped. Results
// come back in order. Reset clears one valid flag per set at once, so there
// is no clearing pass. Write policy and ways_log2 through the register port
// only while no lookup is pending.
module set_assoc_cache_tag_lookup_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [satl_pkg::PADDR_BITS-1:0] paddr,
  input  logic [satl_pkg::PDATA_BITS-1:0] pwdata,
  output logic [satl_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready,
  input  logic                            push,
  output logic                            full,
  input  logic [satl_pkg::ADDR_BITS-1:0]  address_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            hit_o
);

  satl_pkg::cfg_t cfg_q, cfg_d;
  logic           req_valid, req_pop;
  satl_pkg::req_t req;
  logic           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        satl_pkg::REG_POLICY: cfg_d.policy    = satl_pkg::policy_e'(pwdata[0]);
        satl_pkg::REG_WAYS:   cfg_d.ways_log2 = pwdata[satl_pkg::WLOG_BITS-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      satl_pkg::REG_POLICY: prdata = satl_pkg::PDATA_BITS'(cfg_q.policy);
      satl_pkg::REG_WAYS:   prdata = satl_pkg::PDATA_BITS'(cfg_q.ways_log2);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy    <= satl_pkg::POL_LRU;
      cfg_q.ways_log2 <= satl_pkg::WLOG_BITS'(2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  satl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .address_i   (address_i),
    .full_o      (full),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  satl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .hit_o       (hit_o)
  );

endmodule

// File: sv/satl_checker.sv
// Port-level checker for the cache tag lookup, bound to the top level.
`include "set_assoc_cache_tag_lookup_core_assert.svh"

module satl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic hit_o
);

  logic [2:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;
  assign cnt_d   = cnt_q + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `SATL_ASSERT_RST(a_reset_idle, empty && !full)
  `SATL_ASSERT(a_no_phantom, !empty |-> (cnt_q != 3'd0))
  `SATL_ASSERT(a_full_busy, full |-> (cnt_q >= 3'd2))
  `SATL_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(hit_o)))

endmodule

bind set_assoc_cache_tag_lookup_core satl_checker u_checker (.*);
